// File: design/sdff_pkg.sv
package sdff_pkg;

	localparam int MAX_FIELD  = 64;
	localparam int MAX_DIGITS = 20;

	localparam int VALUE_W = 64;
	localparam int FW_W    = 7;
	localparam int PREC_W  = 6;
	localparam int CHAR_W  = 8;

	// binary to BCD: this many magnitude bits per conversion step
	localparam int DD_BITS    = 4;
	localparam int CONV_STEPS = VALUE_W / DD_BITS;
	localparam int CONV_W     = $clog2(CONV_STEPS + 1);
	localparam int BCD_W      = 4 * MAX_DIGITS;

	localparam int CNT_W     = $clog2(MAX_FIELD + 1);
	localparam int NDIG_W    = $clog2(MAX_DIGITS + 1);
	localparam int DIG_IDX_W = $clog2(MAX_DIGITS);

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	// datapath operations
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
	localparam logic [OP_W-1:0] OP_CONV  = 3'd2;
	localparam logic [OP_W-1:0] OP_MEAS  = 3'd3;
	localparam logic [OP_W-1:0] OP_ZCALC = 3'd4;
	localparam logic [OP_W-1:0] OP_PCALC = 3'd5;

	// character sources
	localparam int EM_W = 3;
	localparam logic [EM_W-1:0] EM_NONE  = 3'd0;
	localparam logic [EM_W-1:0] EM_LPAD  = 3'd1;
	localparam logic [EM_W-1:0] EM_SIGN  = 3'd2;
	localparam logic [EM_W-1:0] EM_ZERO  = 3'd3;
	localparam logic [EM_W-1:0] EM_DIGIT = 3'd4;
	localparam logic [EM_W-1:0] EM_RPAD  = 3'd5;

	// jump conditions: when true the step is skipped and control goes to target
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_NEVER      = 3'd0;
	localparam logic [COND_W-1:0] C_ALWAYS     = 3'd1;
	localparam logic [COND_W-1:0] C_CONV_DONE  = 3'd2;
	localparam logic [COND_W-1:0] C_LPAD_DONE  = 3'd3;
	localparam logic [COND_W-1:0] C_NO_SIGN    = 3'd4;
	localparam logic [COND_W-1:0] C_ZEROS_DONE = 3'd5;
	localparam logic [COND_W-1:0] C_DIG_DONE   = 3'd6;
	localparam logic [COND_W-1:0] C_RPAD_DONE  = 3'd7;

	// program steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] ST_CONV   = 4'd1;
	localparam logic [STEP_W-1:0] ST_MEAS   = 4'd2;
	localparam logic [STEP_W-1:0] ST_ZCALC  = 4'd3;
	localparam logic [STEP_W-1:0] ST_PCALC  = 4'd4;
	localparam logic [STEP_W-1:0] ST_LPAD   = 4'd5;
	localparam logic [STEP_W-1:0] ST_SIGN   = 4'd6;
	localparam logic [STEP_W-1:0] ST_ZEROS  = 4'd7;
	localparam logic [STEP_W-1:0] ST_DIGITS = 4'd8;
	localparam logic [STEP_W-1:0] ST_RPAD   = 4'd9;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [EM_W-1:0]   emit;
		logic [COND_W-1:0] cond;
		logic              loop;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic            fire;
		logic [OP_W-1:0] op;
		logic [EM_W-1:0] emit;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic conv_done;
		logic pad_zero;
		logic left;
		logic has_sign;
		logic zeros_zero;
		logic ndig_zero;
	} status_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_NONE, emit: EM_NONE, cond: C_NEVER, loop: 1'b0, target: ST_IDLE};
		case (pc)
			ST_IDLE: begin
				w.op = OP_LOAD;
			end
			ST_CONV: begin
				w.op = OP_CONV;
				w.cond = C_CONV_DONE;
				w.loop = 1'b1;
				w.target = ST_MEAS;
			end
			ST_MEAS: begin
				w.op = OP_MEAS;
			end
			ST_ZCALC: begin
				w.op = OP_ZCALC;
			end
			ST_PCALC: begin
				w.op = OP_PCALC;
			end
			ST_LPAD: begin
				w.emit = EM_LPAD;
				w.cond = C_LPAD_DONE;
				w.loop = 1'b1;
				w.target = ST_SIGN;
			end
			ST_SIGN: begin
				w.emit = EM_SIGN;
				w.cond = C_NO_SIGN;
				w.target = ST_ZEROS;
			end
			ST_ZEROS: begin
				w.emit = EM_ZERO;
				w.cond = C_ZEROS_DONE;
				w.loop = 1'b1;
				w.target = ST_DIGITS;
			end
			ST_DIGITS: begin
				w.emit = EM_DIGIT;
				w.cond = C_DIG_DONE;
				w.loop = 1'b1;
				w.target = ST_RPAD;
			end
			ST_RPAD: begin
				w.emit = EM_RPAD;
				w.cond = C_RPAD_DONE;
				w.loop = 1'b1;
				w.target = ST_IDLE;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: design/sdff_ifs.sv
interface sdff_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [sdff_pkg::VALUE_W-1:0] value;
	logic        [sdff_pkg::FW_W-1:0]    field_width;
	logic        [sdff_pkg::PREC_W-1:0]  min_digits;
	logic                                has_precision;
	logic                                left_justify;
	logic                                force_plus;
	logic                                space_sign;
	logic                                zero_fill;

	modport source (
		output valid, value, field_width, min_digits, has_precision,
		       left_justify, force_plus, space_sign, zero_fill,
		input  ready
	);
	modport sink (
		input  valid, value, field_width, min_digits, has_precision,
		       left_justify, force_plus, space_sign, zero_fill,
		output ready
	);
endinterface

interface sdff_out_if;
	logic                          valid;
	logic                          ready;
	logic [sdff_pkg::CHAR_W-1:0]   character;
	logic                          last_char;

	modport source (output valid, character, last_char, input ready);
	modport sink (input valid, character, last_char, output ready);
endinterface

// File: design/sdff_seq.sv
module sdff_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  sdff_pkg::status_t sts,
	output sdff_pkg::ctrl_t   ctrl
);
	import sdff_pkg::*;

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_d;
	ucode_t            word;
	logic              skip;
	logic              hold;
	logic              fire;

	assign word = ucode_rom(pc_q);

	always_comb begin
		case (word.cond)
			C_NEVER:      skip = 1'b0;
			C_ALWAYS:     skip = 1'b1;
			C_CONV_DONE:  skip = sts.conv_done;
			C_LPAD_DONE:  skip = sts.pad_zero | sts.left;
			C_NO_SIGN:    skip = ~sts.has_sign;
			C_ZEROS_DONE: skip = sts.zeros_zero;
			C_DIG_DONE:   skip = sts.ndig_zero;
			C_RPAD_DONE:  skip = sts.pad_zero | ~sts.left;
			default:      skip = 1'b1;
		endcase
	end

	// wait for an input transfer, or for room in the output register
	assign hold = ((word.op == OP_LOAD) & ~sts.in_valid)
		| ((word.emit != EM_NONE) & ~sts.out_free);
	assign fire = ~skip & ~hold;

	always_comb begin
		if (skip) begin
			pc_d = word.target;
		end else if (hold || word.loop) begin
			pc_d = pc_q;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign ctrl.fire = fire;
	assign ctrl.op   = word.op;
	assign ctrl.emit = word.emit;

endmodule

// File: design/sdff_dp.sv
module sdff_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sdff_pkg::ctrl_t   ctrl,
	output sdff_pkg::status_t sts,
	sdff_in_if.sink           din,
	sdff_out_if.source        dout
);
	import sdff_pkg::*;

	logic [VALUE_W-1:0]   mag_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [CONV_W-1:0]    conv_q;
	logic                 neg_q;
	logic                 has_prec_q;
	logic                 left_q;
	logic                 plus_q;
	logic                 space_q;
	logic                 zfill_q;
	logic [CNT_W-1:0]     width_q;
	logic [CNT_W-1:0]     prec_q;
	logic [NDIG_W-1:0]    ndig_q;
	logic [CHAR_W-1:0]    sign_q;
	logic                 has_sign_q;
	logic [CNT_W-1:0]     zeros_q;
	logic [CNT_W-1:0]     pad_q;
	logic [CNT_W-1:0]     rem_q;
	logic                 valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;

	logic [CNT_W-1:0]     width_d;
	logic [CNT_W-1:0]     prec_d;
	logic [VALUE_W-1:0]   mag_d;
	logic [BCD_W-1:0]     bcd_d;
	logic [NDIG_W-1:0]    ndig_d;
	logic [CNT_W-1:0]     ndig_ext;
	logic [CNT_W-1:0]     sign_ext;
	logic [CNT_W-1:0]     zeros_d;
	logic [CNT_W-1:0]     body;
	logic [CNT_W-1:0]     pad_d;
	logic [DIG_IDX_W-1:0] dig_idx;
	logic [3:0]           digit;
	logic [CHAR_W-1:0]    char_d;
	logic                 out_free;
	logic                 emit_fire;

	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bit_in);
		logic [BCD_W-1:0] a;
		a = b;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (a[4*i +: 4] >= 4'd5) begin
				a[4*i +: 4] = a[4*i +: 4] + 4'd3;
			end
		end
		return {a[BCD_W-2:0], bit_in};
	endfunction

	assign din.ready = (ctrl.op == OP_LOAD);

	// saturate width and precision to the field limits
	always_comb begin
		if (int'(din.field_width) > MAX_FIELD) begin
			width_d = CNT_W'(MAX_FIELD);
		end else begin
			width_d = CNT_W'(din.field_width);
		end
		if (int'(din.min_digits) > MAX_FIELD - 1) begin
			prec_d = CNT_W'(MAX_FIELD - 1);
		end else begin
			prec_d = CNT_W'(din.min_digits);
		end
	end

	assign mag_d = din.value[VALUE_W-1] ? (~$unsigned(din.value) + 1'b1) : $unsigned(din.value);

	always_comb begin
		bcd_d = bcd_q;
		for (int j = 0; j < DD_BITS; j++) begin
			bcd_d = dabble(bcd_d, mag_q[VALUE_W-1-j]);
		end
	end

	// digit count: highest non-zero digit, one digit for zero unless precision is zero
	always_comb begin
		ndig_d = NDIG_W'(1);
		for (int i = 1; i < MAX_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				ndig_d = NDIG_W'(i + 1);
			end
		end
		if (bcd_q == '0 && has_prec_q && prec_q == '0) begin
			ndig_d = '0;
		end
	end

	assign ndig_ext = CNT_W'(ndig_q);
	assign sign_ext = CNT_W'(has_sign_q);

	always_comb begin
		zeros_d = '0;
		if (has_prec_q) begin
			if (prec_q > ndig_ext) begin
				zeros_d = prec_q - ndig_ext;
			end
		end else if (zfill_q && !left_q) begin
			if (width_q > sign_ext + ndig_ext) begin
				zeros_d = width_q - sign_ext - ndig_ext;
			end
		end
	end

	assign body  = sign_ext + zeros_q + ndig_ext;
	assign pad_d = (width_q > body) ? width_q - body : '0;

	assign dig_idx = DIG_IDX_W'(ndig_q - 1'b1);
	assign digit   = bcd_q[4*dig_idx +: 4];

	always_comb begin
		case (ctrl.emit)
			EM_SIGN:  char_d = sign_q;
			EM_ZERO:  char_d = CH_ZERO;
			EM_DIGIT: char_d = CH_ZERO + {4'd0, digit};
			default:  char_d = CH_SPACE;
		endcase
	end

	assign out_free  = ~valid_q | dout.ready;
	assign emit_fire = ctrl.fire & (ctrl.emit != EM_NONE);

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			case (ctrl.op)
				OP_LOAD: begin
					mag_q      <= mag_d;
					bcd_q      <= '0;
					conv_q     <= CONV_W'(CONV_STEPS);
					neg_q      <= din.value[VALUE_W-1];
					has_prec_q <= din.has_precision;
					left_q     <= din.left_justify;
					plus_q     <= din.force_plus;
					space_q    <= din.space_sign;
					zfill_q    <= din.zero_fill;
					width_q    <= width_d;
					prec_q     <= prec_d;
				end
				OP_CONV: begin
					bcd_q  <= bcd_d;
					mag_q  <= mag_q << DD_BITS;
					conv_q <= conv_q - 1'b1;
				end
				OP_MEAS: begin
					ndig_q     <= ndig_d;
					has_sign_q <= neg_q | plus_q | space_q;
					if (neg_q) begin
						sign_q <= CH_MINUS;
					end else if (plus_q) begin
						sign_q <= CH_PLUS;
					end else begin
						sign_q <= CH_SPACE;
					end
				end
				OP_ZCALC: begin
					zeros_q <= zeros_d;
				end
				OP_PCALC: begin
					pad_q <= pad_d;
					rem_q <= body + pad_d;
				end
				default: begin
				end
			endcase
		end
		if (emit_fire) begin
			rem_q  <= rem_q - 1'b1;
			char_q <= char_d;
			last_q <= (rem_q == CNT_W'(1));
			case (ctrl.emit)
				EM_LPAD, EM_RPAD: pad_q <= pad_q - 1'b1;
				EM_SIGN:          has_sign_q <= 1'b0;
				EM_ZERO:          zeros_q <= zeros_q - 1'b1;
				EM_DIGIT:         ndig_q <= ndig_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_fire) begin
			valid_q <= 1'b1;
		end else if (dout.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign dout.valid     = valid_q;
	assign dout.character = char_q;
	assign dout.last_char = last_q;

	assign sts.in_valid   = din.valid;
	assign sts.out_free   = out_free;
	assign sts.conv_done  = (conv_q == '0);
	assign sts.pad_zero   = (pad_q == '0);
	assign sts.left       = left_q;
	assign sts.has_sign   = has_sign_q;
	assign sts.zeros_zero = (zeros_q == '0);
	assign sts.ndig_zero  = (ndig_q == '0);

endmodule

// File: design/signed_decimal_field_formatter.sv
// Formats one signed 64-bit value per item as a C %ld field, one character per transfer.
// Steps: a load, BCD conversion (4 bits per cycle), the setup steps MEAS, ZCALC and PCALC,
// then the emit steps, each character waiting while the output register is full.
// A new item is accepted only after the previous one has placed its last character in the
// single character output register.
// Reset: arst_n clears the program counter and the output valid flag; no other state.
module signed_decimal_field_formatter (
	input logic        clk,
	input logic        arst_n,
	sdff_in_if.sink    din,
	sdff_out_if.source dout
);
	import sdff_pkg::*;

	ctrl_t   ctrl;
	status_t sts;

	sdff_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctrl   (ctrl)
	);

	sdff_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sts    (sts),
		.din    (din),
		.dout   (dout)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import sdff_pkg::*;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic        [FW_W-1:0]    field_width;
		logic        [PREC_W-1:0]  min_digits;
		logic                      has_precision;
		logic                      left_justify;
		logic                      force_plus;
		logic                      space_sign;
		logic                      zero_fill;
	} field_req_t;

	typedef struct {
		logic [CHAR_W-1:0] character;
		logic              last_char;
	} field_char_t;

	localparam int OUT_HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n;

	sdff_in_if  din_if ();
	sdff_out_if dout_if ();

	signed_decimal_field_formatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	field_req_t  pending_fields[$];
	field_char_t expected_chars[$];

	int   fields_queued = 0;
	int   fields_taken  = 0;
	int   chars_checked = 0;
	int   empty_fields  = 0;
	int   neg_fields    = 0;
	int   errors        = 0;
	bit   calm;
	bit   hold_request;
	int   hold_left;
	logic in_taken;

	always #10 clk = ~clk;

	// Build the C %ld field for one request and append its characters.
	function automatic void format_field(input field_req_t f);
		logic [VALUE_W-1:0] mag;
		logic [CHAR_W-1:0]  digs[MAX_DIGITS];
		logic [CHAR_W-1:0]  sign_ch;
		logic [CHAR_W-1:0]  line[$];
		field_char_t        c;
		int                 ndig, width, prec, sign_len, zeros, body, pad;
		mag = f.value[VALUE_W-1] ? (~f.value + 64'd1) : f.value;
		width = int'(f.field_width);
		prec = int'(f.min_digits);
		if (width > MAX_FIELD) width = MAX_FIELD;
		if (prec > MAX_FIELD - 1) prec = MAX_FIELD - 1;
		ndig = 0;
		if (!(f.has_precision && prec == 0 && mag == 0)) begin
			do begin
				digs[ndig] = CH_ZERO + CHAR_W'(mag % 10);
				mag = mag / 10;
				ndig++;
			end while (mag != 0 && ndig < MAX_DIGITS);
		end
		sign_len = 1;
		if (f.value[VALUE_W-1]) begin
			sign_ch = CH_MINUS;
			neg_fields++;
		end else if (f.force_plus) begin
			sign_ch = CH_PLUS;
		end else if (f.space_sign) begin
			sign_ch = CH_SPACE;
		end else begin
			sign_ch = '0;
			sign_len = 0;
		end
		zeros = 0;
		if (f.has_precision) begin
			if (prec > ndig) zeros = prec - ndig;
		end else if (f.zero_fill && !f.left_justify) begin
			if (width > sign_len + ndig) zeros = width - sign_len - ndig;
		end
		body = sign_len + zeros + ndig;
		pad = (width > body) ? width - body : 0;
		if (!f.left_justify)
			repeat (pad) line.push_back(CH_SPACE);
		if (sign_len != 0) line.push_back(sign_ch);
		repeat (zeros) line.push_back(CH_ZERO);
		for (int i = ndig; i > 0; i--) line.push_back(digs[i-1]);
		if (f.left_justify)
			repeat (pad) line.push_back(CH_SPACE);
		while (line.size() > MAX_FIELD) void'(line.pop_back());
		if (line.size() == 0) empty_fields++;
		foreach (line[i]) begin
			c.character = line[i];
			c.last_char = (i == line.size() - 1);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic field_req_t make_field(input logic signed [VALUE_W-1:0] value,
			input int width, input int prec, input bit hp, input bit lj,
			input bit fp, input bit ss, input bit zf);
		field_req_t f;
		f.value = value;
		f.field_width = FW_W'(width);
		f.min_digits = PREC_W'(prec);
		f.has_precision = hp;
		f.left_justify = lj;
		f.force_plus = fp;
		f.space_sign = ss;
		f.zero_fill = zf;
		return f;
	endfunction

	function automatic field_req_t random_field();
		field_req_t         f;
		logic [VALUE_W-1:0] v;
		int                 near;
		int                 pick;
		pick = $urandom_range(9);
		near = $urandom_range(2000);
		case (pick)
			0: v = {$urandom, $urandom};
			1: begin
				v = {$urandom, $urandom} >> $urandom_range(63);
				if ($urandom_range(1)) v = -v;
			end
			2: v = '0;
			3: v = {1'b1, 63'd0} + $urandom_range(3);
			4: v = {1'b0, {63{1'b1}}} - $urandom_range(3);
			5: v = VALUE_W'($urandom);
			default: v = VALUE_W'(near - 1000);
		endcase
		f.value = v;
		f.field_width = ($urandom_range(7) == 0) ? FW_W'($urandom_range(127))
			: FW_W'($urandom_range(24));
		f.min_digits = ($urandom_range(7) == 0) ? PREC_W'($urandom_range(63))
			: PREC_W'($urandom_range(12));
		f.has_precision = ($urandom_range(2) == 0);
		f.left_justify = 1'($urandom_range(1));
		f.force_plus = 1'($urandom_range(1));
		f.space_sign = 1'($urandom_range(1));
		f.zero_fill = 1'($urandom_range(1));
		// favour the zero value with zero precision
		if (pick == 2 && $urandom_range(1)) begin
			f.has_precision = 1'b1;
			f.min_digits = '0;
		end
		return f;
	endfunction

	task automatic queue_field(input field_req_t f);
		pending_fields.push_back(f);
		fields_queued++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (fields_taken != fields_queued || expected_chars.size() != 0);
	endtask

	always @(negedge clk) begin : drive_fields
		field_req_t f;
		if (!arst_n) begin
			din_if.valid <= 1'b0;
		end else if (!din_if.valid || in_taken) begin
			if (pending_fields.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
				f = pending_fields.pop_front();
				din_if.valid         <= 1'b1;
				din_if.value         <= f.value;
				din_if.field_width   <= f.field_width;
				din_if.min_digits    <= f.min_digits;
				din_if.has_precision <= f.has_precision;
				din_if.left_justify  <= f.left_justify;
				din_if.force_plus    <= f.force_plus;
				din_if.space_sign    <= f.space_sign;
				din_if.zero_fill     <= f.zero_fill;
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			dout_if.ready <= 1'b0;
			hold_left--;
		end else if (hold_request) begin
			// hold off long enough for the block to back up into its input
			hold_request = 1'b0;
			hold_left = OUT_HOLD_CYCLES;
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= calm || $urandom_range(99) >= 21;
		end
	end

	always @(posedge clk) begin : watch
		field_req_t  f;
		field_char_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= din_if.valid && din_if.ready;
			if (din_if.valid && din_if.ready) begin
				f.value         = din_if.value;
				f.field_width   = din_if.field_width;
				f.min_digits    = din_if.min_digits;
				f.has_precision = din_if.has_precision;
				f.left_justify  = din_if.left_justify;
				f.force_plus    = din_if.force_plus;
				f.space_sign    = din_if.space_sign;
				f.zero_fill     = din_if.zero_fill;
				format_field(f);
				fields_taken++;
			end
			if (dout_if.valid && dout_if.ready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected character %h last %b with nothing pending",
						$time, dout_if.character, dout_if.last_char);
					errors++;
				end else begin
					want = expected_chars.pop_front();
					if (dout_if.character !== want.character ||
						dout_if.last_char !== want.last_char) begin
						$display("%0t: mismatch: expected char %h last %b, got char %h last %b",
							$time, want.character, want.last_char,
							dout_if.character, dout_if.last_char);
						errors++;
					end
					chars_checked++;
				end
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.value = '0;
		din_if.field_width = '0;
		din_if.min_digits = '0;
		din_if.has_precision = 1'b0;
		din_if.left_justify = 1'b0;
		din_if.force_plus = 1'b0;
		din_if.space_sign = 1'b0;
		din_if.zero_fill = 1'b0;
		dout_if.ready = 1'b0;
		calm = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		in_taken = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		queue_field(make_field(64'sd0, 0, 0, 0, 0, 0, 0, 0));
		// zero with zero precision: no digits at all, here no characters either
		queue_field(make_field(64'sd0, 0, 0, 1, 0, 0, 0, 0));
		queue_field(make_field(64'sd0, 0, 0, 1, 0, 1, 0, 0));
		queue_field(make_field(64'sd0, 5, 0, 1, 0, 0, 0, 1));
		queue_field(make_field(64'sd0, 3, 0, 1, 1, 0, 1, 0));
		queue_field(make_field({1'b1, 63'd0}, 0, 0, 0, 0, 0, 0, 0));
		queue_field(make_field({1'b1, 63'd0}, 64, 0, 0, 0, 0, 0, 1));
		queue_field(make_field({1'b0, {63{1'b1}}}, 0, 0, 0, 0, 1, 0, 0));
		queue_field(make_field(-64'sd1, 127, 0, 0, 1, 0, 0, 0));
		queue_field(make_field(-64'sd1, 127, 0, 0, 0, 1, 1, 1));
		queue_field(make_field(64'sd42, 10, 0, 0, 0, 0, 1, 1));
		queue_field(make_field(64'sd42, 0, 0, 0, 0, 1, 1, 0));
		queue_field(make_field(64'sd123, 8, 0, 0, 1, 0, 0, 1));
		queue_field(make_field(64'sd123, 10, 5, 1, 0, 0, 0, 1));
		queue_field(make_field(-64'sd7, 64, 63, 1, 0, 0, 0, 0));
		queue_field(make_field(64'sd5, 127, 63, 1, 1, 1, 0, 0));
		queue_field(make_field(64'sd99, 0, 63, 0, 0, 0, 0, 0));
		queue_field(make_field(64'sd0, 64, 0, 0, 0, 1, 0, 1));
		queue_field(make_field(-64'sd123456789, 3, 0, 0, 0, 0, 1, 0));
		queue_field(make_field(64'sd1, 0, 1, 1, 0, 0, 1, 0));
		queue_field(make_field(64'sd9, 2, 0, 0, 1, 0, 1, 0));
		queue_field(make_field(64'sd10, 21, 20, 1, 0, 1, 0, 0));
		wait_drained();

		repeat (90) queue_field(random_field());
		calm = 1'b1;
		repeat (50) queue_field(random_field());
		wait_drained();
		calm = 1'b0;

		// keep offering fields while the output side is held off
		repeat (40) queue_field(random_field());
		hold_request = 1'b1;
		repeat (70) queue_field(random_field());
		wait_drained();
		repeat (100) @(negedge clk);

		$display("Formatted %0d fields (%0d negative, %0d empty), %0d characters checked,",
			fields_taken, neg_fields, empty_fields, chars_checked);
		$display("with random stalls on both sides, a stall-free stretch and a long output hold.");
		if (errors == 0 && expected_chars.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
